// ===== hw/rtl/rarf_pkg.sv =====
// Shared types, codes and limits for the register access request framer.
package rarf_pkg;

   localparam int FRAME_BYTES = 1430;
   localparam int MAX_READS   = 256;
   localparam int MAX_BURST   = 256;
   localparam int ADDR_BITS   = 22;
   localparam int RESULT_MAX  = 6;

   localparam logic [3:0] PROTO_VER   = 4'd1;
   localparam logic [3:0] CMD_VERSION = 4'd1;
   localparam logic [3:0] CMD_ACCESS  = 4'd2;

   localparam logic [1:0] MODE_ACCESS  = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_VERSION = 2'd2;
   localparam logic [1:0] MODE_SENT    = 2'd3;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [2:0] LANE_HALF_LO = 3'd4;
   localparam logic [2:0] LANE_HALF_HI = 3'd5;
   localparam logic [2:0] LANE_WORD    = 3'd6;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_COUNT = 3'd1;
   localparam logic [2:0] ST_ADDR_BIG  = 3'd2;
   localparam logic [2:0] ST_MISALIGN  = 3'd3;
   localparam logic [2:0] ST_REQ_FULL  = 3'd4;
   localparam logic [2:0] ST_REP_FULL  = 3'd5;
   localparam logic [2:0] ST_READ_FULL = 3'd6;
   localparam logic [2:0] ST_STRAY     = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] byte_address;
      logic [1:0]  access_size;
      logic [8:0]  burst_count;
      logic        is_read;
      logic [31:0] write_data;
   } req_type;

   // Everything one request produces: up to six bytes plus shared fields.
   typedef struct packed {
      logic                          has_byte;
      logic [2:0]                    count;
      logic [RESULT_MAX-1:0][7:0]    bytes;
      logic [10:0]                   base;
      logic [2:0]                    status;
      logic [10:0]                   req_total;
      logic [10:0]                   rep_total;
   } plan_type;

endpackage

// ===== hw/rtl/register_access_request_framer.sv =====
// Top level of the register access request framer.
// Each request is captured in an input register, decoded combinationally into a
// plan of up to six frame bytes (2-byte header when a frame opens, a
// little-endian command word, or 2 or 4 write data bytes), and the plan is
// loaded into a result register that hands out one byte per cycle while
// rsp_ready is high. A request yields one result with no byte for errors,
// stray data or frame sent, two bytes for a header or a byte/16-bit data
// element, four for a 32-bit element or a command in an open frame, six for a
// command that opens a frame. The byte-wide result port sets the pace; the
// input register takes the next request while the current plan drains, and
// the next plan loads as the last byte is taken. Frame state (sequence number,
// request and reply lengths, queued reads, pending write elements) updates at
// the moment a plan is loaded. No clearing pass after reset.
module register_access_request_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_byte_address,
   input  logic [1:0]  req_access_size,
   input  logic [8:0]  req_burst_count,
   input  logic        req_is_read,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_byte_value,
   output logic [10:0] rsp_byte_offset,
   output logic [2:0]  rsp_status,
   output logic [10:0] rsp_request_total,
   output logic [10:0] rsp_reply_total,
   output logic        rsp_last
);
   import rarf_pkg::*;

   logic     req_valid_ff;
   req_type  req_ff;
   plan_type plan;
   logic     free, load;

   // plan moves to the result register when that register is empty or
   // its last byte is taken this cycle
   assign load      = req_valid_ff && free;
   assign req_ready = !req_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.mode         <= req_mode;
         req_ff.byte_address <= req_byte_address;
         req_ff.access_size  <= req_access_size;
         req_ff.burst_count  <= req_burst_count;
         req_ff.is_read      <= req_is_read;
         req_ff.write_data   <= req_write_data;
      end
   end

   rarf_core u_core (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .item  (req_ff),
      .plan  (plan)
   );

   rarf_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .plan              (plan),
      .free              (free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_status        (rsp_status),
      .rsp_request_total (rsp_request_total),
      .rsp_reply_total   (rsp_reply_total),
      .rsp_last          (rsp_last)
   );

   // a result without a byte is always the only one for its request
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_last)
      else $error("empty result not marked last");

   // a multi-byte plan keeps presenting until its last byte
   a_plan_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("result stream broke inside a request");

   // byte offsets within one request step by one
   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_has_byte && !rsp_last
      |=> rsp_byte_offset == 11'($past(rsp_byte_offset) + 11'd1))
      else $error("byte offset did not advance");

   // taking a request while one is held means the held one moves on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_valid_ff |-> load)
      else $error("held request overwritten");

endmodule

// ===== hw/rtl/rarf_core.sv =====
// Frame state registers and the single-pass request decode into a result plan.
module rarf_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rarf_pkg::req_type  item,
   output rarf_pkg::plan_type plan
);
   import rarf_pkg::*;

   logic [3:0]  seq_ff, seq_in;
   logic [10:0] reqlen_ff, reqlen_in;
   logic [10:0] replen_ff, replen_in;
   logic [8:0]  rdcnt_ff, rdcnt_in;
   logic [8:0]  wrem_ff, wrem_in;
   logic [2:0]  wlane_ff, wlane_in;

   logic [1:0]  lo;
   logic [2:0]  lane;
   logic        mis, bad_cnt, too_big, opening;
   logic [10:0] reqlen_h, replen_h, dat, req_add, rep_add;
   logic [8:0]  rdcnt_h;
   logic        req_full, rep_full, reads_full;
   logic [31:0] word;
   logic [7:0]  seq_byte;
   logic [7:0]  cnt_m1;

   assign lo = item.byte_address[1:0];

   always_comb begin
      mis  = 1'b0;
      lane = {1'b0, lo};
      case (item.access_size)
         SIZE_BYTE: lane = {1'b0, lo};
         SIZE_HALF: begin
            if (lo == 2'd0) lane = LANE_HALF_LO;
            else if (lo == 2'd2) lane = LANE_HALF_HI;
            else mis = 1'b1;
         end
         SIZE_WORD: begin
            lane = LANE_WORD;
            mis  = (lo != 2'd0);
         end
         default: mis = 1'b1;
      endcase
   end

   assign bad_cnt  = (item.burst_count == 9'd0) || (item.burst_count > 9'(MAX_BURST));
   assign too_big  = |item.byte_address[31:ADDR_BITS];
   assign opening  = (reqlen_ff == 11'd0);
   assign reqlen_h = opening ? 11'd2 : reqlen_ff;
   assign replen_h = opening ? 11'd2 : replen_ff;
   assign rdcnt_h  = opening ? 9'd0 : rdcnt_ff;

   // data bytes per burst: 2 per element, 4 for the full-word lane
   assign dat     = (lane == LANE_WORD) ? {item.burst_count, 2'b00}
                                        : {1'b0, item.burst_count, 1'b0};
   assign req_add = 11'd4 + (item.is_read ? 11'd0 : dat);
   assign rep_add = item.is_read ? dat : 11'd0;

   assign req_full   = ({1'b0, reqlen_h} + {1'b0, req_add}) > 12'(FRAME_BYTES);
   assign rep_full   = ({1'b0, replen_h} + {1'b0, rep_add} + 12'd2) > 12'(FRAME_BYTES);
   assign reads_full = item.is_read && (rdcnt_h >= 9'(MAX_READS));

   assign cnt_m1   = 8'(item.burst_count - 9'd1);
   assign word     = {item.is_read, lane, cnt_m1, item.byte_address[ADDR_BITS-1:2]};
   assign seq_byte = {4'd0, seq_ff};

   always_comb begin
      seq_in    = seq_ff;
      reqlen_in = reqlen_ff;
      replen_in = replen_ff;
      rdcnt_in  = rdcnt_ff;
      wrem_in   = wrem_ff;
      wlane_in  = wlane_ff;

      plan          = '0;
      plan.count    = 3'd1;
      plan.status   = ST_OK;

      case (item.mode)
         MODE_ACCESS: begin
            if (mis) plan.status = ST_MISALIGN;
            else if (bad_cnt) plan.status = ST_BAD_COUNT;
            else if (too_big) plan.status = ST_ADDR_BIG;
            else begin
               wrem_in = 9'd0;
               if (opening) begin
                  seq_in    = seq_ff + 4'd1;
                  reqlen_in = 11'd2;
                  replen_in = 11'd2;
                  rdcnt_in  = 9'd0;
               end
               plan.base = opening ? 11'd0 : reqlen_ff;
               if (req_full) plan.status = ST_REQ_FULL;
               else if (rep_full) plan.status = ST_REP_FULL;
               else if (reads_full) plan.status = ST_READ_FULL;

               if (plan.status != ST_OK) begin
                  // header, if one went out, stays in the frame
                  if (opening) begin
                     plan.has_byte = 1'b1;
                     plan.count    = 3'd2;
                     plan.bytes    = {32'd0, seq_byte, CMD_ACCESS, PROTO_VER};
                  end
               end else begin
                  plan.has_byte = 1'b1;
                  if (opening) begin
                     plan.count = 3'd6;
                     plan.bytes = {word, seq_byte, CMD_ACCESS, PROTO_VER};
                  end else begin
                     plan.count = 3'd4;
                     plan.bytes = {16'd0, word};
                  end
                  reqlen_in = reqlen_h + 11'd4;
                  if (item.is_read) begin
                     replen_in = replen_h + rep_add;
                     rdcnt_in  = rdcnt_h + 9'd1;
                  end else begin
                     wrem_in  = item.burst_count;
                     wlane_in = lane;
                  end
               end
            end
         end
         MODE_WRITE: begin
            if (wrem_ff == 9'd0) plan.status = ST_STRAY;
            else begin
               plan.has_byte = 1'b1;
               plan.base     = reqlen_ff;
               if (!wlane_ff[2]) begin
                  // byte lane: data byte then zero pad
                  plan.count = 3'd2;
                  plan.bytes = {40'd0, item.write_data[7:0]};
               end else if (wlane_ff != LANE_WORD) begin
                  plan.count = 3'd2;
                  plan.bytes = {32'd0, item.write_data[15:0]};
               end else begin
                  plan.count = 3'd4;
                  plan.bytes = {16'd0, item.write_data};
               end
               reqlen_in = reqlen_ff + 11'(plan.count);
               wrem_in   = wrem_ff - 9'd1;
            end
         end
         MODE_VERSION: begin
            plan.has_byte = 1'b1;
            plan.count    = 3'd2;
            plan.bytes    = {32'd0, seq_byte, CMD_VERSION, PROTO_VER};
            seq_in        = seq_ff + 4'd1;
            reqlen_in     = 11'd2;
            replen_in     = 11'd2;
            rdcnt_in      = 9'd0;
            wrem_in       = 9'd0;
         end
         default: begin
            reqlen_in = 11'd0;
            replen_in = 11'd0;
            rdcnt_in  = 9'd0;
            wrem_in   = 9'd0;
         end
      endcase

      plan.req_total = reqlen_in;
      plan.rep_total = replen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         reqlen_ff <= '0;
         replen_ff <= '0;
         rdcnt_ff  <= '0;
         wrem_ff   <= '0;
         wlane_ff  <= '0;
      end else if (load) begin
         seq_ff    <= seq_in;
         reqlen_ff <= reqlen_in;
         replen_ff <= replen_in;
         rdcnt_ff  <= rdcnt_in;
         wrem_ff   <= wrem_in;
         wlane_ff  <= wlane_in;
      end
   end

endmodule

// ===== hw/rtl/rarf_emit.sv =====
// Result register: holds one plan and hands its bytes out one per cycle while rsp_ready is high.
module rarf_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rarf_pkg::plan_type plan,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_byte,
   output logic [7:0]         rsp_byte_value,
   output logic [10:0]        rsp_byte_offset,
   output logic [2:0]         rsp_status,
   output logic [10:0]        rsp_request_total,
   output logic [10:0]        rsp_reply_total,
   output logic               rsp_last
);
   import rarf_pkg::*;

   logic     full_ff;
   logic [2:0] idx_ff;
   plan_type plan_ff;

   assign rsp_valid         = full_ff;
   assign rsp_last          = (idx_ff + 3'd1) == plan_ff.count;
   assign rsp_has_byte      = plan_ff.has_byte;
   assign rsp_byte_value    = plan_ff.bytes[idx_ff];
   assign rsp_byte_offset   = plan_ff.has_byte ? plan_ff.base + 11'(idx_ff) : 11'd0;
   assign rsp_status        = plan_ff.status;
   assign rsp_request_total = plan_ff.req_total;
   assign rsp_reply_total   = plan_ff.rep_total;

   assign free = !full_ff || (rsp_ready && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         full_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (full_ff && rsp_ready) begin
         if (rsp_last) full_ff <= 1'b0;
         else idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) plan_ff <= plan;
   end

endmodule
